/* rtl/core/tspm_pkg.sv */
// ----------------------------------------------------------------------------
// tspm_pkg
// Widths, types and constants of the three-step phase and magnitude block.
// ----------------------------------------------------------------------------
package tspm_pkg;

	localparam int SAMPLE_BITS  = 8;
	localparam int PHASE_BITS   = 16;
	localparam int MAG_W        = 8;
	localparam int ACC_W        = 32;
	localparam int CORDIC_STEPS = 28;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);

	localparam int X_W        = SAMPLE_BITS + 2;
	localparam int D_W        = SAMPLE_BITS + 1;
	localparam int CW         = SAMPLE_BITS + 20;
	localparam int X_SHIFT    = 16;
	localparam int V_W        = 2 * SAMPLE_BITS + 4;
	localparam int SQRT_STEPS = V_W / 2;
	localparam int SQRT_TOP   = V_W - 2;

	localparam logic signed [CW-1:0] SQRT3_Q16 = CW'(113512);
	localparam logic [ACC_W-1:0]     HALF_TURN = ACC_W'(1) << (ACC_W - 1);
	localparam logic [ACC_W-1:0]     ROUND_ADD = ACC_W'(1) << (ACC_W - 1 - PHASE_BITS);
	localparam logic [MAG_W-1:0]     MAG_MAX   = '1;

	localparam logic [ACC_W-1:0] ANGLE_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005
	};

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [PHASE_BITS-1:0]  phase_t;
	typedef logic [MAG_W-1:0]       mag_t;

	typedef struct packed {
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic [ACC_W-1:0]     acc;
		logic [V_W-1:0]       rem;
		logic [V_W-1:0]       root;
		logic                 bypass;
		logic                 half;
	} cell_t;

endpackage

/* rtl/core/tspm_in_if.sv */
// ----------------------------------------------------------------------------
// tspm_in_if
// Pixel triple channel: valid, ready and the three samples.
// ----------------------------------------------------------------------------
interface tspm_in_if;
	import tspm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t first_sample;
	sample_t second_sample;
	sample_t third_sample;

	modport source (output valid, output first_sample, output second_sample,
		output third_sample, input ready);
	modport sink (input valid, input first_sample, input second_sample,
		input third_sample, output ready);
endinterface

/* rtl/core/tspm_out_if.sv */
// ----------------------------------------------------------------------------
// tspm_out_if
// Result channel: valid, ready, wrapped phase and modulation.
// ----------------------------------------------------------------------------
interface tspm_out_if;
	import tspm_pkg::*;

	logic   valid;
	logic   ready;
	phase_t wrapped_phase;
	mag_t   modulation;

	modport source (output valid, output wrapped_phase, output modulation, input ready);
	modport sink (input valid, input wrapped_phase, input modulation, output ready);
endinterface

/* rtl/core/tspm_prep.sv */
// ----------------------------------------------------------------------------
// tspm_prep
// Front stage: forms x, y and 4*(x^2 + 3*d^2), folds x into the right half.
// ----------------------------------------------------------------------------
module tspm_prep (
	input  logic               clk,
	input  logic               arst_n,
	tspm_in_if.sink            samples,
	output logic               out_valid,
	input  logic               out_ready,
	output tspm_pkg::cell_t    out_data
);
	import tspm_pkg::*;

	logic                  valid_q;
	cell_t                 data_q;
	cell_t                 nxt;
	logic signed [X_W-1:0] x;
	logic signed [D_W-1:0] d;
	logic [X_W-2:0]        ax;
	logic [D_W-2:0]        ad;
	logic [V_W-1:0]        sqx;
	logic [V_W-1:0]        sqd;
	logic signed [CW-1:0]  xs_raw;
	logic signed [CW-1:0]  ys_raw;

	assign samples.ready = !valid_q || out_ready;

	always_comb begin
		x = $signed({1'b0, samples.first_sample, 1'b0})
			- $signed({2'b00, samples.second_sample})
			- $signed({2'b00, samples.third_sample});
		d = $signed({1'b0, samples.second_sample}) - $signed({1'b0, samples.third_sample});
		ax = x[X_W-1] ? (X_W-1)'(-x) : x[X_W-2:0];
		ad = d[D_W-1] ? (D_W-1)'(-d) : d[D_W-2:0];
		sqx = V_W'(ax) * V_W'(ax);
		sqd = V_W'(ad) * V_W'(ad);
		xs_raw = CW'(x) <<< X_SHIFT;
		ys_raw = CW'(d) * SQRT3_Q16;

		nxt.rem    = (sqx + (sqd << 1) + sqd) << 2;
		nxt.root   = '0;
		nxt.bypass = (d == '0);
		nxt.half   = x[X_W-1];
		if (x[X_W-1]) begin
			nxt.xs  = -xs_raw;
			nxt.ys  = -ys_raw;
			nxt.acc = HALF_TURN;
		end else begin
			nxt.xs  = xs_raw;
			nxt.ys  = ys_raw;
			nxt.acc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (samples.ready) begin
			valid_q <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

/* rtl/core/tspm_cell.sv */
// ----------------------------------------------------------------------------
// tspm_cell
// One CORDIC vectoring step plus, for steps 0 to 9, one digit of the magnitude square root.
// ----------------------------------------------------------------------------
module tspm_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tspm_pkg::STEP_W-1:0]   step,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tspm_pkg::cell_t               in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tspm_pkg::cell_t               out_data
);
	import tspm_pkg::*;

	logic                 valid_q;
	cell_t                data_q;
	cell_t                nxt;
	logic signed [CW-1:0] sx;
	logic signed [CW-1:0] sy;
	logic [ACC_W-1:0]     ang;
	logic [V_W:0]         bitv;
	logic [V_W:0]         trial;

	assign in_ready = !valid_q || out_ready;

	always_comb begin
		nxt   = in_data;
		sx    = $signed(in_data.xs) >>> step;
		sy    = $signed(in_data.ys) >>> step;
		ang   = ANGLE_TAB[step];
		bitv  = '0;
		trial = '0;
		if (!in_data.ys[CW-1]) begin
			nxt.xs  = in_data.xs + sy;
			nxt.ys  = in_data.ys - sx;
			nxt.acc = in_data.acc + ang;
		end else begin
			nxt.xs  = in_data.xs - sy;
			nxt.ys  = in_data.ys + sx;
			nxt.acc = in_data.acc - ang;
		end
		if (int'(step) < SQRT_STEPS) begin
			bitv  = {{V_W{1'b0}}, 1'b1} << (SQRT_TOP - 2 * int'(step));
			trial = {1'b0, in_data.root} + bitv;
			if ({1'b0, in_data.rem} >= trial) begin
				nxt.rem  = in_data.rem - trial[V_W-1:0];
				nxt.root = (in_data.root >> 1) + bitv[V_W-1:0];
			end else begin
				nxt.root = in_data.root >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
endmodule

/* rtl/core/three_step_phase_magnitude.sv */
// ----------------------------------------------------------------------------
// three_step_phase_magnitude: wrapped phase and modulation of a pixel triple
// Pipeline from input transfer to result valid: front stage, 28 CORDIC
// cells, output register; it holds its contents while the output stalls.
// Throughput: one pixel per cycle while the output does not stall, set by the one-step-per-cell chain.
// Reset clears all valid flags at once; the datapath carries no reset.
// ----------------------------------------------------------------------------
module three_step_phase_magnitude (
	input  logic        clk,
	input  logic        arst_n,
	tspm_in_if.sink     samples,
	tspm_out_if.source  result
);
	import tspm_pkg::*;

	cell_t                 link_data [CORDIC_STEPS+1];
	logic [CORDIC_STEPS:0] link_valid;
	logic [CORDIC_STEPS:0] link_ready;

	logic             res_valid_q;
	phase_t           phase_q;
	mag_t             mag_q;
	logic             fin_ready;
	logic [ACC_W-1:0] rnd_acc;
	logic [V_W-1:0]   rnd_mag;
	phase_t           phase_nxt;
	mag_t             mag_nxt;

	tspm_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.out_data  (link_data[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		tspm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (STEP_W'(i)),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_data   (link_data[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_data  (link_data[i+1])
		);
	end

	assign fin_ready                = !res_valid_q || result.ready;
	assign link_ready[CORDIC_STEPS] = fin_ready;

	always_comb begin
		rnd_acc = link_data[CORDIC_STEPS].acc + ROUND_ADD;
		rnd_mag = (link_data[CORDIC_STEPS].root + V_W'(1)) >> 1;
		if (link_data[CORDIC_STEPS].bypass) begin
			phase_nxt = link_data[CORDIC_STEPS].half ? HALF_TURN[ACC_W-1 -: PHASE_BITS] : '0;
		end else begin
			phase_nxt = rnd_acc[ACC_W-1 -: PHASE_BITS];
		end
		mag_nxt = (rnd_mag > V_W'(MAG_MAX)) ? MAG_MAX : rnd_mag[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_ready) begin
			res_valid_q <= link_valid[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (link_valid[CORDIC_STEPS] && fin_ready) begin
			phase_q <= phase_nxt;
			mag_q   <= mag_nxt;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.wrapped_phase = phase_q;
	assign result.modulation    = mag_q;
endmodule

/* rtl/core/tspm_check.sv */
// ----------------------------------------------------------------------------
// tspm_check
// Port-level checks of the phase and magnitude block, bound to its top level.
// ----------------------------------------------------------------------------
module tspm_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input tspm_pkg::phase_t     wrapped_phase,
	input tspm_pkg::mag_t       modulation
);
	import tspm_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(wrapped_phase) && $stable(modulation))
		else $error("stalled result changed");

	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_zero_mag_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (modulation == '0) |-> (wrapped_phase == '0))
		else $error("zero modulation with nonzero phase");
endmodule

bind three_step_phase_magnitude tspm_check u_tspm_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (samples.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.wrapped_phase (result.wrapped_phase),
	.modulation    (result.modulation)
);
